/* rtl/pes_pkg.sv */
package pes_pkg;

   localparam int ARENA_BYTES = 1024;
   localparam int AW          = $clog2(ARENA_BYTES);
   localparam int LW          = AW + 1;

   typedef logic [AW-1:0] addr_type;
   typedef logic [LW-1:0] len_type;
   typedef logic [LW:0]   sum_type;
   typedef logic [7:0]    byte_type;
   typedef logic [9:0]    off_type;
   typedef logic [9:0]    count_type;
   typedef logic [10:0]   used_type;
   typedef logic [8:0]    idx_type;
   typedef logic [9:0]    boff_type;
   typedef logic [2:0]    req_code_type;
   typedef logic [1:0]    status_type;

   localparam req_code_type REQ_SET   = 3'd0;
   localparam req_code_type REQ_GET   = 3'd1;
   localparam req_code_type REQ_UNSET = 3'd2;
   localparam req_code_type REQ_COUNT = 3'd3;
   localparam req_code_type REQ_ENTRY = 3'd4;
   localparam req_code_type REQ_READ  = 3'd5;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_ABSENT  = 2'd1;
   localparam status_type ST_NO_ROOM = 2'd2;
   localparam status_type ST_RANGE   = 2'd3;

   localparam byte_type CH_EQ = 8'h3D;
   localparam byte_type CH_LA = 8'h61;
   localparam byte_type CH_LZ = 8'h7A;
   localparam byte_type CH_UA = 8'h41;
   localparam byte_type CH_NUL = 8'h00;

   typedef struct packed {
      len_type name_bytes;
      len_type value_len;
      logic    overflow;
   } stage_stat_type;

   function automatic byte_type upcase(input byte_type b);
      byte_type r;
      r = b;
      if (b >= CH_LA && b <= CH_LZ) begin
         r = b - CH_LA + CH_UA;
      end
      return r;
   endfunction

endpackage

/* rtl/packed_environment_store_core.sv */
// Packed NAME=VALUE store. After reset the block runs a clearing pass over
// all ARENA_BYTES (1024) arena bytes and holds req_stall high meanwhile.
// Streamed items without last are taken while the block is idle: name bytes
// are upcased into staging, value bytes staged as they are. The item with
// last runs the request on one sequencer over the single-port arena memory:
// get and unset walk the used bytes once, and an unset then compacts the
// entries after the match; set may walk three times (search, compaction
// with tail zeroing, append of name, '=', value and terminator); count and
// entry-by-index walk the used bytes; a byte read reads one arena byte.
// req_stall is high from the last transfer until the result has been loaded
// into the output register; a result that waits on rsp_stall does not block
// further streamed items.
module packed_environment_store_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [2:0]   req_type,
   input  logic [7:0]   req_data_byte,
   input  logic         req_has_byte,
   input  logic         req_is_value,
   input  logic         req_last,
   input  logic [8:0]   req_entry_index,
   input  logic [9:0]   req_byte_offset,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [1:0]   rsp_status,
   output logic [9:0]   rsp_offset,
   output logic [9:0]   rsp_entry_count,
   output logic [7:0]   rsp_read_data,
   output logic [10:0]  rsp_used_bytes
);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DISPATCH,
      S_LK_START, S_LK_RD, S_LK_NAME, S_SK_RD, S_SK_CHK, S_END_RD, S_END_CHK,
      S_LK_DONE, S_MV_RD, S_MV_WR, S_ZR, S_AP_RD, S_AP_WR,
      S_CT_RD, S_CT_CHK, S_EN_TOP, S_EN_RD, S_EN_CHK, S_RD_RD, S_RD_CHK, S_FIN
   } state_type;

   state_type                 state_ff, state_in;
   pes_pkg::len_type          used_ff, used_in, pos_ff, pos_in, scan_ff, scan_in;
   pes_pkg::len_type          fpos_ff, fpos_in, ftail_ff, ftail_in;
   pes_pkg::len_type          src_ff, src_in, dst_ff, dst_in, k_ff, k_in, cnt_ff, cnt_in;
   logic                      mism_ff, mism_in, found_ff, found_in;
   pes_pkg::req_code_type     typ_ff, typ_in;
   pes_pkg::idx_type          want_ff, want_in;
   pes_pkg::boff_type         boff_ff, boff_in;
   pes_pkg::status_type       res_status_ff, res_status_in;
   pes_pkg::off_type          res_offset_ff, res_offset_in;
   pes_pkg::byte_type         res_rd_ff, res_rd_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   pes_pkg::status_type       rsp_status_ff, rsp_status_in;
   pes_pkg::off_type          rsp_offset_ff, rsp_offset_in;
   pes_pkg::count_type        rsp_count_ff, rsp_count_in;
   pes_pkg::byte_type         rsp_rd_ff, rsp_rd_in;
   pes_pkg::used_type         rsp_used_ff, rsp_used_in;

   pes_pkg::byte_type         arena_mem [pes_pkg::ARENA_BYTES];
   pes_pkg::byte_type         ar_rd_ff;
   logic                      ar_we;
   pes_pkg::addr_type         ar_addr;
   pes_pkg::byte_type         ar_wdata;

   logic                      take, stg_clear;
   pes_pkg::addr_type         stg_addr;
   pes_pkg::byte_type         stg_rd;
   pes_pkg::stage_stat_type   stat;
   pes_pkg::sum_type          total, need;
   pes_pkg::len_type          old_sz, name_idx;

   assign take      = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   pes_stage u_stage (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .req_code  (req_type),
      .data_byte (req_data_byte),
      .has_byte  (req_has_byte),
      .is_value  (req_is_value),
      .clear     (stg_clear),
      .rd_addr   (stg_addr),
      .rd_data   (stg_rd),
      .stat      (stat)
   );

   // bytes an appended entry takes: name, '=', value, terminator
   assign total    = pes_pkg::sum_type'(stat.name_bytes) + pes_pkg::sum_type'(stat.value_len)
                     + pes_pkg::sum_type'(2);
   assign old_sz   = found_ff ? (ftail_ff - fpos_ff) : '0;
   assign need     = pes_pkg::sum_type'(used_ff) - pes_pkg::sum_type'(old_sz) + total;
   assign name_idx = scan_ff - pos_ff;

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      pos_in        = pos_ff;
      scan_in       = scan_ff;
      fpos_in       = fpos_ff;
      ftail_in      = ftail_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      k_in          = k_ff;
      cnt_in        = cnt_ff;
      mism_in       = mism_ff;
      found_in      = found_ff;
      typ_in        = typ_ff;
      want_in       = want_ff;
      boff_in       = boff_ff;
      res_status_in = res_status_ff;
      res_offset_in = res_offset_ff;
      res_rd_in     = res_rd_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_rd_in     = rsp_rd_ff;
      rsp_used_in   = rsp_used_ff;
      ar_we         = 1'b0;
      ar_addr       = pes_pkg::addr_type'(scan_ff);
      ar_wdata      = pes_pkg::CH_NUL;
      stg_addr      = pes_pkg::addr_type'(name_idx);
      stg_clear     = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            // zero the arena one byte a cycle
            ar_we   = 1'b1;
            ar_addr = pes_pkg::addr_type'(dst_ff);
            dst_in  = dst_ff + pes_pkg::len_type'(1);
            if (dst_ff == pes_pkg::len_type'(pes_pkg::ARENA_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (take && req_last) begin
               typ_in   = req_type;
               want_in  = req_entry_index;
               boff_in  = req_byte_offset;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            res_status_in = pes_pkg::ST_OK;
            res_offset_in = '0;
            res_rd_in     = '0;
            cnt_in        = '0;
            pos_in        = '0;
            k_in          = '0;
            found_in      = 1'b0;
            case (typ_ff)
               pes_pkg::REQ_SET: begin
                  if (stat.overflow) begin
                     res_status_in = pes_pkg::ST_NO_ROOM;
                     state_in      = S_FIN;
                  end else begin
                     state_in = S_LK_START;
                  end
               end
               pes_pkg::REQ_GET, pes_pkg::REQ_UNSET: state_in = S_LK_START;
               pes_pkg::REQ_COUNT:                   state_in = S_CT_RD;
               pes_pkg::REQ_ENTRY:                   state_in = S_EN_TOP;
               pes_pkg::REQ_READ:                    state_in = S_RD_RD;
               default:                              state_in = S_FIN;
            endcase
         end
         S_LK_START: begin
            scan_in = pos_ff;
            mism_in = 1'b0;
            if (stat.overflow || pos_ff >= used_ff) begin
               found_in = 1'b0;
               state_in = S_LK_DONE;
            end else begin
               state_in = S_LK_RD;
            end
         end
         S_LK_RD: begin
            // fetch arena name byte and matching staged byte together
            if (scan_ff >= used_ff) begin
               found_in = 1'b0;
               state_in = S_LK_DONE;
            end else begin
               state_in = S_LK_NAME;
            end
         end
         S_LK_NAME: begin
            if (ar_rd_ff == pes_pkg::CH_EQ) begin
               if (name_idx == stat.name_bytes && !mism_ff) begin
                  found_in = 1'b1;
                  fpos_in  = pos_ff;
                  state_in = S_END_RD;
               end else begin
                  state_in = S_SK_RD;
               end
            end else if (ar_rd_ff == pes_pkg::CH_NUL) begin
               found_in = 1'b0;
               state_in = S_LK_DONE;
            end else begin
               if (name_idx < stat.name_bytes &&
                   pes_pkg::upcase(ar_rd_ff) != pes_pkg::upcase(stg_rd)) begin
                  mism_in = 1'b1;
               end
               scan_in  = scan_ff + pes_pkg::len_type'(1);
               state_in = S_LK_RD;
            end
         end
         S_SK_RD: begin
            if (scan_ff >= used_ff) begin
               pos_in   = scan_ff + pes_pkg::len_type'(1);
               state_in = S_LK_START;
            end else begin
               state_in = S_SK_CHK;
            end
         end
         S_SK_CHK: begin
            if (ar_rd_ff == pes_pkg::CH_NUL) begin
               pos_in   = scan_ff + pes_pkg::len_type'(1);
               state_in = S_LK_START;
            end else begin
               scan_in  = scan_ff + pes_pkg::len_type'(1);
               state_in = S_SK_RD;
            end
         end
         S_END_RD: begin
            if (scan_ff >= used_ff) begin
               ftail_in = used_ff;
               state_in = S_LK_DONE;
            end else begin
               state_in = S_END_CHK;
            end
         end
         S_END_CHK: begin
            if (ar_rd_ff == pes_pkg::CH_NUL) begin
               ftail_in = scan_ff + pes_pkg::len_type'(1);
               state_in = S_LK_DONE;
            end else begin
               scan_in  = scan_ff + pes_pkg::len_type'(1);
               state_in = S_END_RD;
            end
         end
         S_LK_DONE: begin
            src_in = ftail_ff;
            dst_in = fpos_ff;
            k_in   = '0;
            case (typ_ff)
               pes_pkg::REQ_SET: begin
                  if (need > pes_pkg::sum_type'(pes_pkg::ARENA_BYTES)) begin
                     res_status_in = pes_pkg::ST_NO_ROOM;
                     state_in      = S_FIN;
                  end else if (found_ff) begin
                     state_in = S_MV_RD;
                  end else begin
                     state_in = S_AP_RD;
                  end
               end
               pes_pkg::REQ_GET: begin
                  if (found_ff) begin
                     res_offset_in = pes_pkg::off_type'(fpos_ff + stat.name_bytes
                                                        + pes_pkg::len_type'(1));
                  end else begin
                     res_status_in = pes_pkg::ST_ABSENT;
                  end
                  state_in = S_FIN;
               end
               default: begin
                  if (found_ff) begin
                     state_in = S_MV_RD;
                  end else begin
                     res_status_in = pes_pkg::ST_ABSENT;
                     state_in      = S_FIN;
                  end
               end
            endcase
         end
         S_MV_RD: begin
            // compact: pull the bytes after the entry down over it
            ar_addr = pes_pkg::addr_type'(src_ff);
            if (src_ff >= used_ff) begin
               state_in = S_ZR;
            end else begin
               state_in = S_MV_WR;
            end
         end
         S_MV_WR: begin
            ar_we    = 1'b1;
            ar_addr  = pes_pkg::addr_type'(dst_ff);
            ar_wdata = ar_rd_ff;
            src_in   = src_ff + pes_pkg::len_type'(1);
            dst_in   = dst_ff + pes_pkg::len_type'(1);
            state_in = S_MV_RD;
         end
         S_ZR: begin
            // zero the freed tail, then shrink the used length
            ar_addr = pes_pkg::addr_type'(dst_ff);
            if (dst_ff >= used_ff) begin
               used_in = used_ff - (ftail_ff - fpos_ff);
               k_in    = '0;
               state_in = (typ_ff == pes_pkg::REQ_SET) ? S_AP_RD : S_FIN;
            end else begin
               ar_we  = 1'b1;
               dst_in = dst_ff + pes_pkg::len_type'(1);
            end
         end
         S_AP_RD: begin
            stg_addr = (k_ff <= stat.name_bytes) ? pes_pkg::addr_type'(k_ff)
                                               : pes_pkg::addr_type'(k_ff - pes_pkg::len_type'(1));
            if (pes_pkg::sum_type'(k_ff) == total) begin
               used_in  = pes_pkg::len_type'(pes_pkg::sum_type'(used_ff) + total);
               state_in = S_FIN;
            end else begin
               state_in = S_AP_WR;
            end
         end
         S_AP_WR: begin
            ar_we   = 1'b1;
            ar_addr = pes_pkg::addr_type'(used_ff + k_ff);
            if (k_ff == stat.name_bytes) begin
               ar_wdata = pes_pkg::CH_EQ;
            end else if (pes_pkg::sum_type'(k_ff) == total - pes_pkg::sum_type'(1)) begin
               ar_wdata = pes_pkg::CH_NUL;
            end else begin
               ar_wdata = stg_rd;
            end
            k_in     = k_ff + pes_pkg::len_type'(1);
            state_in = S_AP_RD;
         end
         S_CT_RD: begin
            ar_addr = pes_pkg::addr_type'(k_ff);
            if (k_ff >= used_ff) begin
               state_in = S_FIN;
            end else begin
               state_in = S_CT_CHK;
            end
         end
         S_CT_CHK: begin
            if (ar_rd_ff == pes_pkg::CH_NUL) begin
               cnt_in = cnt_ff + pes_pkg::len_type'(1);
            end
            k_in     = k_ff + pes_pkg::len_type'(1);
            state_in = S_CT_RD;
         end
         S_EN_TOP: begin
            scan_in = pos_ff;
            if (pos_ff >= used_ff) begin
               res_status_in = pes_pkg::ST_RANGE;
               state_in      = S_FIN;
            end else if (k_ff == pes_pkg::len_type'(want_ff)) begin
               res_offset_in = pes_pkg::off_type'(pos_ff);
               state_in      = S_FIN;
            end else begin
               state_in = S_EN_RD;
            end
         end
         S_EN_RD: begin
            if (scan_ff >= used_ff) begin
               pos_in   = scan_ff + pes_pkg::len_type'(1);
               k_in     = k_ff + pes_pkg::len_type'(1);
               state_in = S_EN_TOP;
            end else begin
               state_in = S_EN_CHK;
            end
         end
         S_EN_CHK: begin
            if (ar_rd_ff == pes_pkg::CH_NUL) begin
               pos_in   = scan_ff + pes_pkg::len_type'(1);
               k_in     = k_ff + pes_pkg::len_type'(1);
               state_in = S_EN_TOP;
            end else begin
               scan_in  = scan_ff + pes_pkg::len_type'(1);
               state_in = S_EN_RD;
            end
         end
         S_RD_RD: begin
            ar_addr = pes_pkg::addr_type'(boff_ff);
            state_in = (pes_pkg::len_type'(boff_ff) >= used_ff) ? S_FIN : S_RD_CHK;
         end
         S_RD_CHK: begin
            res_rd_in = ar_rd_ff;
            state_in  = S_FIN;
         end
         S_FIN: begin
            // hold until the output register is free
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_offset_in = res_offset_ff;
               rsp_count_in  = pes_pkg::count_type'(cnt_ff);
               rsp_rd_in     = res_rd_ff;
               rsp_used_in   = pes_pkg::used_type'(used_ff);
               stg_clear     = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         used_ff      <= '0;
         dst_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         dst_ff       <= dst_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      scan_ff       <= scan_in;
      fpos_ff       <= fpos_in;
      ftail_ff      <= ftail_in;
      src_ff        <= src_in;
      k_ff          <= k_in;
      cnt_ff        <= cnt_in;
      mism_ff       <= mism_in;
      found_ff      <= found_in;
      typ_ff        <= typ_in;
      want_ff       <= want_in;
      boff_ff       <= boff_in;
      res_status_ff <= res_status_in;
      res_offset_ff <= res_offset_in;
      res_rd_ff     <= res_rd_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_rd_ff     <= rsp_rd_in;
      rsp_used_ff   <= rsp_used_in;
   end

   // arena: one port, registered read
   always_ff @(posedge clock) begin
      if (ar_we) begin
         arena_mem[ar_addr] <= ar_wdata;
      end
      ar_rd_ff <= arena_mem[ar_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_offset      = rsp_offset_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_read_data   = rsp_rd_ff;
   assign rsp_used_bytes  = rsp_used_ff;

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= pes_pkg::len_type'(pes_pkg::ARENA_BYTES))
      else $error("used length beyond arena");
   a_exec_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last) |=> req_stall)
      else $error("final transfer did not start execution");
   a_append_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_AP_WR) |->
         (pes_pkg::sum_type'(used_ff) + pes_pkg::sum_type'(k_ff))
            < pes_pkg::sum_type'(pes_pkg::ARENA_BYTES))
      else $error("append past arena end");
`endif

endmodule

/* rtl/pes_stage.sv */
module pes_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    take,
   input  pes_pkg::req_code_type   req_code,
   input  pes_pkg::byte_type       data_byte,
   input  logic                    has_byte,
   input  logic                    is_value,
   input  logic                    clear,
   input  pes_pkg::addr_type       rd_addr,
   output pes_pkg::byte_type       rd_data,
   output pes_pkg::stage_stat_type stat
);

   pes_pkg::byte_type stage_mem [pes_pkg::ARENA_BYTES];
   pes_pkg::byte_type rd_data_ff;
   pes_pkg::len_type  nlen_ff, nlen_in, vlen_ff, vlen_in;
   logic              ovf_ff, ovf_in, pe_ff, pe_in, ivp_ff, ivp_in;
   logic              val, wr_en;
   pes_pkg::len_type  fill;
   pes_pkg::addr_type wr_addr;
   pes_pkg::byte_type wr_data;

   assign val     = (req_code == pes_pkg::REQ_SET) && is_value;
   assign fill    = nlen_ff + vlen_ff;
   assign wr_addr = val ? pes_pkg::addr_type'(fill) : pes_pkg::addr_type'(nlen_ff);
   assign wr_data = val ? data_byte : pes_pkg::upcase(data_byte);

   always_comb begin
      nlen_in = nlen_ff;
      vlen_in = vlen_ff;
      ovf_in  = ovf_ff;
      pe_in   = pe_ff;
      ivp_in  = ivp_ff;
      wr_en   = 1'b0;
      if (clear) begin
         nlen_in = '0;
         vlen_in = '0;
         ovf_in  = 1'b0;
         pe_in   = 1'b0;
         ivp_in  = 1'b0;
      end else if (take && req_code <= pes_pkg::REQ_UNSET) begin
         if (val && !ivp_ff) begin
            ivp_in = 1'b1;
            pe_in  = 1'b0;
         end
         if (!val && ivp_ff) begin
            ivp_in = ivp_ff;
         end else if (!has_byte || pe_in) begin
            ivp_in = ivp_in;
         end else if (data_byte == pes_pkg::CH_NUL) begin
            pe_in = 1'b1;
         end else if (fill >= pes_pkg::len_type'(pes_pkg::ARENA_BYTES)) begin
            ovf_in = 1'b1;
         end else begin
            wr_en = 1'b1;
            if (val) begin
               vlen_in = vlen_ff + pes_pkg::len_type'(1);
            end else begin
               nlen_in = nlen_ff + pes_pkg::len_type'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nlen_ff <= '0;
         vlen_ff <= '0;
         ovf_ff  <= 1'b0;
         pe_ff   <= 1'b0;
         ivp_ff  <= 1'b0;
      end else begin
         nlen_ff <= nlen_in;
         vlen_ff <= vlen_in;
         ovf_ff  <= ovf_in;
         pe_ff   <= pe_in;
         ivp_ff  <= ivp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stage_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= stage_mem[rd_addr];
   end

   assign rd_data         = rd_data_ff;
   assign stat.name_bytes = nlen_ff;
   assign stat.value_len  = vlen_ff;
   assign stat.overflow   = ovf_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill <= pes_pkg::len_type'(pes_pkg::ARENA_BYTES))
      else $error("staged bytes exceed arena size");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      clear |=> (nlen_ff == '0 && vlen_ff == '0 && !ovf_ff))
      else $error("staging not cleared");
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> fill == pes_pkg::len_type'(pes_pkg::ARENA_BYTES))
      else $error("overflow flagged with room left");
`endif

endmodule

/* dv/packed_environment_store_checker.sv */
`timescale 1ns / 1ps

module packed_environment_store_checker
   import pes_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_is_value,
   input  logic        req_last,
   input  logic [8:0]  req_entry_index,
   input  logic [9:0]  req_byte_offset,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [9:0]  rsp_offset,
   input  logic [9:0]  rsp_entry_count,
   input  logic [7:0]  rsp_read_data,
   input  logic [10:0] rsp_used_bytes,
   output int          fail_count,
   output int          awaited
);

   typedef struct packed {
      status_type status;
      off_type    offset;
      count_type  entry_count;
      byte_type   read_data;
      used_type   used_bytes;
   } reply_type;

   byte_type  store [ARENA_BYTES];
   byte_type  held [ARENA_BYTES];
   int        fill;
   int        key_bytes;
   int        value_len;
   bit        held_overflow;
   bit        part_done;
   bit        in_value;
   reply_type replies [$];

   assign awaited = replies.size();

   function automatic byte_type to_upper(byte_type b);
      if (b >= CH_LA && b <= CH_LZ) return b - CH_LA + CH_UA;
      return b;
   endfunction

   // start of the binding whose name equals the held name, or -1
   function automatic int find_binding();
      int pos;
      int scan;
      bit same;
      pos = 0;
      if (held_overflow) return -1;
      while (pos < fill) begin
         scan = pos;
         while (scan < fill && store[scan] != CH_EQ && store[scan] != CH_NUL) scan++;
         if (scan >= fill || store[scan] != CH_EQ) break;
         if (scan - pos == key_bytes) begin
            same = 1;
            for (int i = 0; i < key_bytes; i++) begin
               if (to_upper(store[pos+i]) != to_upper(held[i])) same = 0;
            end
            if (same) return pos;
         end
         while (pos < fill && store[pos] != CH_NUL) pos++;
         pos++;
      end
      return -1;
   endfunction

   function automatic int binding_size(int pos);
      int n;
      n = 0;
      while (pos + n < fill && store[pos+n] != CH_NUL) n++;
      n++;
      if (n > fill - pos) n = fill - pos;
      return n;
   endfunction

   function automatic void drop_binding(int pos);
      int sz;
      sz = binding_size(pos);
      for (int i = pos; i < fill - sz; i++) store[i] = store[i+sz];
      for (int i = fill - sz; i < fill; i++) store[i] = CH_NUL;
      fill -= sz;
   endfunction

   function automatic status_type bind_name();
      int old;
      int old_sz;
      int p;
      old_sz = 0;
      if (held_overflow) return ST_NO_ROOM;
      old = find_binding();
      if (old >= 0) old_sz = binding_size(old);
      if (fill - old_sz + key_bytes + value_len + 2 > ARENA_BYTES) return ST_NO_ROOM;
      if (old >= 0) drop_binding(old);
      p = fill;
      for (int i = 0; i < key_bytes; i++) store[p++] = held[i];
      store[p++] = CH_EQ;
      for (int i = 0; i < value_len; i++) store[p++] = held[key_bytes+i];
      store[p++] = CH_NUL;
      fill = p;
      return ST_OK;
   endfunction

   function automatic void hold_byte();
      bit is_val;
      if (req_type > REQ_UNSET) return;
      is_val = (req_type == REQ_SET) && req_is_value;
      if (is_val && !in_value) begin
         in_value  = 1;
         part_done = 0;
      end
      if (!is_val && in_value) return;
      if (!req_has_byte || part_done) return;
      if (req_data_byte == CH_NUL) begin
         part_done = 1;
         return;
      end
      if (key_bytes + value_len >= ARENA_BYTES) begin
         held_overflow = 1;
         return;
      end
      if (is_val) begin
         held[key_bytes+value_len] = req_data_byte;
         value_len++;
      end else begin
         held[key_bytes] = to_upper(req_data_byte);
         key_bytes++;
      end
   endfunction

   function automatic void run_request();
      reply_type r;
      int pos;
      int k;
      r = '0;
      case (req_type)
         REQ_SET: r.status = bind_name();
         REQ_GET, REQ_UNSET: begin
            pos = find_binding();
            if (pos < 0) r.status = ST_ABSENT;
            else if (req_type == REQ_GET) r.offset = off_type'(pos + key_bytes + 1);
            else drop_binding(pos);
         end
         REQ_COUNT: begin
            for (int i = 0; i < fill; i++) if (store[i] == CH_NUL) r.entry_count++;
         end
         REQ_ENTRY: begin
            pos = 0;
            k = 0;
            r.status = ST_RANGE;
            while (pos < fill) begin
               if (k == int'(req_entry_index)) begin
                  r.status = ST_OK;
                  r.offset = off_type'(pos);
                  break;
               end
               while (pos < fill && store[pos] != CH_NUL) pos++;
               pos++;
               k++;
            end
         end
         REQ_READ: if (int'(req_byte_offset) < fill) r.read_data = store[req_byte_offset];
         default: ;
      endcase
      r.used_bytes  = used_type'(fill);
      key_bytes     = 0;
      value_len     = 0;
      held_overflow = 0;
      part_done     = 0;
      in_value      = 0;
      replies.push_back(r);
   endfunction

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         for (int i = 0; i < ARENA_BYTES; i++) store[i] = CH_NUL;
         fill          = 0;
         key_bytes     = 0;
         value_len     = 0;
         held_overflow = 0;
         part_done     = 0;
         in_value      = 0;
         fail_count    = 0;
         replies.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (replies.size() == 0) begin
               $display("%0t: unexpected reply status %0d used %0d", $time,
                        rsp_status, rsp_used_bytes);
               fail_count++;
            end else begin
               want = replies.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status exp %0d got %0d", $time, want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_offset !== want.offset) begin
                  $display("%0t: offset exp %0d got %0d", $time, want.offset, rsp_offset);
                  fail_count++;
               end
               if (rsp_entry_count !== want.entry_count) begin
                  $display("%0t: entry_count exp %0d got %0d", $time, want.entry_count,
                           rsp_entry_count);
                  fail_count++;
               end
               if (rsp_read_data !== want.read_data) begin
                  $display("%0t: read_data exp %h got %h", $time, want.read_data,
                           rsp_read_data);
                  fail_count++;
               end
               if (rsp_used_bytes !== want.used_bytes) begin
                  $display("%0t: used_bytes exp %0d got %0d", $time, want.used_bytes,
                           rsp_used_bytes);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            hold_byte();
            if (req_last) run_request();
         end
      end
   end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import pes_pkg::*;

   // request codes the block does not define; they must leave the store alone
   localparam req_code_type REQ_SPARE_LO = 3'd6;
   localparam req_code_type REQ_SPARE_HI = 3'd7;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_type;
   logic [7:0]  req_data_byte;
   logic        req_has_byte;
   logic        req_is_value;
   logic        req_last;
   logic [8:0]  req_entry_index;
   logic [9:0]  req_byte_offset;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [9:0]  rsp_offset;
   logic [9:0]  rsp_entry_count;
   logic [7:0]  rsp_read_data;
   logic [10:0] rsp_used_bytes;
   int          fail_count;
   int          awaited;
   int          send_idle_pct;
   int          take_idle_pct;
   int          transfers;

   packed_environment_store_core u_top (.*);

   packed_environment_store_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // receiver back-pressure; the percentage changes per phase
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < take_idle_pct);
   end

   // Offer one item and hold it until the block takes it. Idle cycles drop
   // valid first; with no idle the valid stays high across transfers.
   task automatic offer(input logic [2:0] kind, input logic [7:0] data, input logic has,
                        input logic is_val, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_data_byte   <= data;
      req_has_byte    <= has;
      req_is_value    <= is_val;
      req_last        <= fin;
      req_entry_index <= ($urandom_range(3) == 0) ? 9'($urandom) : 9'($urandom_range(9));
      req_byte_offset <= ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(80));
      do @(posedge clock); while (req_stall);
      transfers++;
   endtask

   // name bytes from a small alphabet so that bindings collide often
   function automatic logic [7:0] name_char();
      case ($urandom_range(9))
         0: return "a";
         1: return "A";
         2: return "z";
         3: return "Z";
         4: return "b";
         5: return "B";
         6: return "_";
         7: return 8'($urandom);
         8: return CH_NUL;
         default: return "q";
      endcase
   endfunction

   // one random request: mostly well formed, some noise and broken streams
   task automatic random_request();
      int pick;
      int n;
      pick = $urandom_range(99);
      if (pick < 38) begin
         n = $urandom_range(3);
         for (int i = 0; i < n; i++) offer(REQ_SET, name_char(), $urandom_range(7) != 0,
                                           1'b0, 1'b0);
         n = $urandom_range(4);
         for (int i = 0; i < n; i++) offer(REQ_SET, ($urandom_range(7) == 0) ? CH_NUL :
                                           8'($urandom_range(255, 1)),
                                           $urandom_range(7) != 0, 1'b1, 1'b0);
         // a stray name byte; dropped if a value byte came before it
         if ($urandom_range(5) == 0) offer(REQ_SET, "a", 1'b1, 1'b0, 1'b0);
         offer(REQ_SET, 8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
      end else if (pick < 62) begin
         n = $urandom_range(3);
         for (int i = 0; i < n; i++) offer((pick < 50) ? REQ_GET : REQ_UNSET, name_char(),
                                           1'b1, 1'($urandom_range(1)), 1'b0);
         offer((pick < 50) ? REQ_GET : REQ_UNSET, name_char(), 1'($urandom_range(1)),
               1'($urandom_range(1)), 1'b1);
      end else if (pick < 70) begin
         offer(REQ_COUNT, 8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
      end else if (pick < 80) begin
         offer(REQ_ENTRY, 8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
      end else if (pick < 93) begin
         offer(REQ_READ, 8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
      end else begin
         offer(3'($urandom_range(REQ_SPARE_HI, REQ_COUNT)), 8'($urandom),
               1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
   endtask

   initial begin
      req_valid       = 1'b0;
      req_type        = REQ_SET;
      req_data_byte   = 8'h00;
      req_has_byte    = 1'b0;
      req_is_value    = 1'b0;
      req_last        = 1'b0;
      req_entry_index = '0;
      req_byte_offset = '0;
      rsp_stall       = 1'b0;
      send_idle_pct   = 0;
      take_idle_pct   = 0;
      transfers       = 0;
      reset           = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: lower-case set, case-blind get and replace, the edges
      offer(REQ_SET, "p", 1'b1, 1'b0, 1'b0);
      offer(REQ_SET, "x", 1'b1, 1'b1, 1'b0);
      offer(REQ_SET, 8'hFF, 1'b1, 1'b1, 1'b1);
      offer(REQ_GET, "P", 1'b1, 1'b1, 1'b1);
      offer(REQ_SET, "P", 1'b1, 1'b0, 1'b0);
      offer(REQ_SET, CH_NUL, 1'b1, 1'b0, 1'b0);    // zero ends the name
      offer(REQ_SET, "q", 1'b1, 1'b0, 1'b0);       // dropped
      offer(REQ_SET, 8'h80, 1'b1, 1'b1, 1'b1);
      offer(REQ_SET, CH_NUL, 1'b0, 1'b0, 1'b1);    // empty name and value
      offer(REQ_COUNT, 8'hAA, 1'b1, 1'b0, 1'b1);
      offer(REQ_ENTRY, 8'h00, 1'b0, 1'b0, 1'b1);
      offer(REQ_READ, 8'h00, 1'b0, 1'b0, 1'b1);
      offer(REQ_SPARE_LO, 8'h00, 1'b0, 1'b0, 1'b1);
      offer(REQ_SPARE_HI, 8'h00, 1'b0, 1'b0, 1'b1);
      offer(REQ_UNSET, "m", 1'b1, 1'b0, 1'b1);     // absent name
      offer(REQ_UNSET, "p", 1'b1, 1'b0, 1'b1);

      // random: receiver-heavy idling, then sender-heavy, then none
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 49 : 0;
         take_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 16 : 0;
         transfers = 0;
         while (transfers < 58) random_request();
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (awaited != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && awaited == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // hang guard, well beyond the slowest legal run
   initial begin
      #200ms;
      $display("FAIL");
      $finish;
   end

endmodule
